### src/bbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants for the 3x3 boundary extractor
// Field widths, register codes, reset values and the result record that
// travels from the window logic to the output queue.
// ----------------------------------------------------------------------------
package bbe_pkg;

    // Fixed field widths.
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Defaults for the top-level parameters and the register reset values.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int FW_RESET       = 1024;
    localparam int FH_RESET       = 4096;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Up to three results per pixel; the output queue must be a power of two.
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 eroded;
        logic                 boundary;
        logic                 last;
    } t_result;

    // Results produced by one pixel, packed from item 0 upwards.
    typedef struct packed {
        logic [RES_CNT_W-1:0]       count;
        t_result [MAX_RES-1:0]      item;
    } t_res_group;

endpackage

### src/bbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_ram: generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module bbe_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bbe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_core: window and result logic
// Holds the two-column window, forms the 3x3 erosion and builds the group
// of up to three results for the pixel in the input register.
// ----------------------------------------------------------------------------
module bbe_core #(
    parameter int ROW_W = 12,
    parameter int COL_W = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_valid,
    input  logic [ROW_W-1:0]           i_row,
    input  logic [COL_W-1:0]           i_col,
    input  logic                       i_pix,
    input  logic [1:0]                 i_stored,
    input  logic [ROW_W-1:0]           i_hlast,
    input  logic [COL_W-1:0]           i_wlast,
    output bbe_pkg::t_res_group        o_grp,
    output logic [1:0]                 o_wr_data
);
    import bbe_pkg::*;

    logic [5:0]       r_win;
    logic [5:0]       n_win;
    logic [2:0]       cur;
    logic [2:0]       w1;
    logic [2:0]       w2;
    logic             mid;
    logic             top;
    logic             ero;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    logic [2:0]       v;
    t_result          res [MAX_RES];

    function automatic logic [ROW_OUT_W-1:0] fmt_row(input logic [ROW_W-1:0] x);
        logic [31:0] t;
        t = 32'(x);
        return t[ROW_OUT_W-1:0];
    endfunction

    function automatic logic [COL_OUT_W-1:0] fmt_col(input logic [COL_W-1:0] x);
        logic [31:0] t;
        t = 32'(x);
        return t[COL_OUT_W-1:0];
    endfunction

    // Pixel columns: bit 0 is two rows up, bit 2 is the current row.
    assign mid = i_stored[0];
    assign top = i_stored[1];
    assign cur = {i_pix, mid, top};
    assign w1  = r_win[2:0];
    assign w2  = r_win[5:3];

    assign row_m1 = i_row - ROW_W'(1);
    assign col_m1 = i_col - COL_W'(1);

    // The centre pixel sits one row and one column back; it is interior
    // only when it is at least one pixel away from the top and left edges.
    assign ero = (i_row >= ROW_W'(2)) && (i_col >= COL_W'(2))
               && (&cur) && (&w1) && (&w2);

    // Which results this pixel releases.
    assign v[0] = i_valid && (i_row != '0) && (i_col != '0);
    assign v[1] = i_valid && (i_row != '0) && (i_col == i_wlast);
    assign v[2] = i_valid && (i_row == i_hlast);

    always_comb begin
        res[0].row      = fmt_row(row_m1);
        res[0].col      = fmt_col(col_m1);
        res[0].eroded   = ero;
        res[0].boundary = w1[1] & ~ero;
        res[0].last     = !v[1] && !v[2];

        res[1].row      = fmt_row(row_m1);
        res[1].col      = fmt_col(i_col);
        res[1].eroded   = 1'b0;
        res[1].boundary = mid;
        res[1].last     = !v[2];

        res[2].row      = fmt_row(i_row);
        res[2].col      = fmt_col(i_col);
        res[2].eroded   = 1'b0;
        res[2].boundary = i_pix;
        res[2].last     = 1'b1;
    end

    // Pack the released results into the lowest slots, in order.
    always_comb begin
        logic [RES_CNT_W-1:0] idx;
        idx        = '0;
        o_grp.item = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            if (v[k]) begin
                o_grp.item[idx] = res[k];
                idx             = idx + RES_CNT_W'(1);
            end
        end
        o_grp.count = idx;
    end

    // Entry written back to the line store: the two most recent rows.
    assign o_wr_data = {mid, i_pix};

    // Window shifts by one column per pixel; a frame-register write empties it.
    assign n_win = {w1, cur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_win <= '0;
        end else if (i_valid) begin
            r_win <= n_win;
        end
    end

endmodule

### src/bbe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_fifo: result queue
// Takes up to three results per cycle and hands them out one per
// transaction; its head entry drives the output ports.
// ----------------------------------------------------------------------------
module bbe_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bbe_pkg::t_res_group            i_grp,
    input  logic                           i_pop,
    output bbe_pkg::t_result               o_head,
    output logic                           o_valid,
    output logic [bbe_pkg::FIFO_LVL_W-1:0] o_level
);
    import bbe_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_LVL_W-1:0] r_level;
    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] n_rd_ptr;
    logic [FIFO_LVL_W-1:0] n_level;
    logic                  pop;

    assign o_valid = (r_level != '0);
    assign pop     = i_pop && o_valid;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    // Pointer and fill-level update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_grp.count);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_level  = r_level + FIFO_LVL_W'(i_grp.count) - FIFO_LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Storage: the packed group lands in consecutive slots.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(i_grp.count)) begin
                r_mem[FIFO_PTR_W'(r_wr_ptr + FIFO_PTR_W'(k))] <= i_grp.item[k];
            end
        end
    end

endmodule

### src/binary_boundary_extract_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_boundary_extract_3x3: streaming 3x3 erosion and boundary extraction
// Takes binary pixels in raster order and reports, for every pixel, its
// erosion and boundary together with its row and column.
//
//   Channel   Direction  Handshake                  Payload
//   pixel     in         i_valid / o_ready          i_pixel
//   result    out        o_valid / i_ready          o_out_row, o_out_col,
//                                                   o_eroded, o_boundary,
//                                                   o_last_of_run
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel is accepted per cycle while o_ready is high. A pixel sits in the
// input register while its line store entry is read, and its results are
// then registered into the output queue, from whose head they are taken.
// Each pixel yields up to three results; o_ready drops when the eight-entry
// output queue could not hold a further three, so a stalled output side or
// long runs of line-end results pace the input. Reset is synchronous and
// clears counters, window and queue; the line store needs no clearing.
// ----------------------------------------------------------------------------
module binary_boundary_extract_3x3 #(
    parameter int MAX_WIDTH  = bbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel input.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_pixel,
    // Result output.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bbe_pkg::ROW_OUT_W-1:0]    o_out_row,
    output logic [bbe_pkg::COL_OUT_W-1:0]    o_out_col,
    output logic                             o_eroded,
    output logic                             o_boundary,
    output logic                             o_last_of_run,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bbe_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Clamp a register value to 1..MAX and return the last index.
    function automatic logic [COL_W-1:0] width_last(input logic [FW_W-1:0] fw);
        int v;
        v = int'(fw);
        if (v == 0) begin
            v = 1;
        end else if (v > MAX_WIDTH) begin
            v = MAX_WIDTH;
        end
        return COL_W'(v - 1);
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [FH_W-1:0] fh);
        int v;
        v = int'(fh);
        if (v == 0) begin
            v = 1;
        end else if (v > MAX_HEIGHT) begin
            v = MAX_HEIGHT;
        end
        return ROW_W'(v - 1);
    endfunction

    logic [COL_W-1:0]      r_wlast;
    logic [ROW_W-1:0]      r_hlast;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      n_row;
    logic                  r_s1_valid;
    logic [COL_W-1:0]      r_s1_col;
    logic [ROW_W-1:0]      r_s1_row;
    logic                  r_s1_pix;
    logic                  r_byp;
    logic [1:0]            r_byp_data;
    logic                  accept;
    logic                  cfg_wr;
    logic                  cfg_hit;
    logic [1:0]            ram_rdata;
    logic [1:0]            stored;
    logic [1:0]            wr_data;
    t_res_group            grp;
    t_result               head;
    logic [FIFO_LVL_W-1:0] level;

    // Configuration port is always open; valid indexes restart the frame.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_hit     = cfg_wr && ((i_cfg_index == REG_FRAME_WIDTH)
                                 || (i_cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= width_last(FW_W'(FW_RESET));
            r_hlast <= height_last(FH_W'(FH_RESET));
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_wlast <= width_last(i_cfg_data[FW_W-1:0]);
                end
                REG_FRAME_HEIGHT: begin
                    r_hlast <= height_last(i_cfg_data[FH_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Room for the pending group plus a full group from the next pixel.
    always_comb begin
        logic [FIFO_LVL_W:0] need;
        need    = (FIFO_LVL_W+1)'(level) + (FIFO_LVL_W+1)'(grp.count)
                + (FIFO_LVL_W+1)'(MAX_RES);
        o_ready = (need <= (FIFO_LVL_W+1)'(FIFO_DEPTH));
    end

    assign accept = i_valid && o_ready;

    // Raster position of the next pixel, wrapping at the end of the frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col >= r_wlast) begin
            n_col = '0;
            n_row = (r_row >= r_hlast) ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_pix <= i_pixel;
        end
    end

    // A one-column frame reads the entry that is being written at the same
    // edge; the written value is forwarded in place of the stale read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (accept) begin
            r_byp <= r_s1_valid && (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_data <= wr_data;
        end
    end

    assign stored = r_byp ? r_byp_data : ram_rdata;

    // Line store: the two previous rows at each column.
    bbe_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Window and result logic.
    bbe_core #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_hit),
        .i_valid   (r_s1_valid),
        .i_row     (r_s1_row),
        .i_col     (r_s1_col),
        .i_pix     (r_s1_pix),
        .i_stored  (stored),
        .i_hlast   (r_hlast),
        .i_wlast   (r_wlast),
        .o_grp     (grp),
        .o_wr_data (wr_data)
    );

    // Output queue.
    bbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grp   (grp),
        .i_pop   (i_ready),
        .o_head  (head),
        .o_valid (o_valid),
        .o_level (level)
    );

    assign o_out_row     = head.row;
    assign o_out_col     = head.col;
    assign o_eroded      = head.eroded;
    assign o_boundary    = head.boundary;
    assign o_last_of_run = head.last;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 binary boundary extractor
// Streams binary pixels through frames of many geometries, including the
// clamped, tiny and widest ones, with random gaps on the pixel side and
// random stalls on the result side. A predictor tracks the line store, the
// window and the position counters, and every result is compared field by
// field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
    import bbe_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 360;
    localparam int ERR_PRINT_MAX = 40;

    // Indexes past the register list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic                  i_pixel       = 1'b0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [ROW_OUT_W-1:0]  o_out_row;
    logic [COL_OUT_W-1:0]  o_out_col;
    logic                  o_eroded;
    logic                  o_boundary;
    logic                  o_last_of_run;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    binary_boundary_extract_3x3 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_eroded      (o_eroded),
        .o_boundary    (o_boundary),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Stimulus and expectation stores.
    logic    pix_pending[$];
    t_result boundary_expect[$];

    // Handshake flags, set at the rising edge and read at the falling edge.
    bit pix_taken = 1'b0;
    bit res_taken = 1'b0;
    bit cfg_taken = 1'b0;

    int pix_gap   = 0;
    int pix_burst = 0;
    int res_stall = 0;
    int res_burst = 0;

    int pix_issued    = 0;
    int pix_accepted  = 0;
    int res_checked   = 0;
    int cfg_writes    = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;
    int directed_pix  = 0;

    // Predictor state: two previous rows per column, the last two window
    // columns, the next pixel position and the geometry registers.
    logic [1:0]       line_mem [MAX_W] = '{default: 2'b00};
    logic [5:0]       win_cols   = '0;
    int               cur_row    = 0;
    int               cur_col    = 0;
    logic [FW_W-1:0]  reg_width  = FW_W'(FW_RESET);
    logic [FH_W-1:0]  reg_height = FH_W'(FH_RESET);

    // Clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_error(input string what);
        err_count++;
        if (err_count <= ERR_PRINT_MAX) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
    endtask

    // Idle length for the next transaction, with occasional stretches of none.
    task automatic draw_idle(inout int burst, output int idle);
        if (burst > 0) begin
            burst--;
            idle = 0;
        end else begin
            idle = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) begin
                burst = $urandom_range(8, 40);
            end
        end
    endtask

    // Geometry in use, after clamping of out-of-range register values.
    function automatic int eff_width();
        if (reg_width == 0) return 1;
        if (reg_width > MAX_W) return MAX_W;
        return int'(reg_width);
    endfunction

    function automatic int eff_height();
        if (reg_height == 0) return 1;
        if (reg_height > MAX_H) return MAX_H;
        return int'(reg_height);
    endfunction

    function automatic t_result make_result(input int r, input int c,
                                            input logic pix, input logic ero);
        t_result res;
        res.row      = ROW_OUT_W'(r);
        res.col      = COL_OUT_W'(c);
        res.eroded   = ero;
        res.boundary = pix & ~ero;
        res.last     = 1'b0;
        return res;
    endfunction

    // Works out the results caused by one pixel and advances the state.
    task automatic predict_boundary(input logic pix);
        int         w;
        int         h;
        int         r;
        int         c;
        int         n;
        logic [1:0] stored;
        logic       mid;
        logic       top;
        logic [2:0] cur;
        logic [2:0] w1;
        logic [2:0] w2;
        logic       ero;
        t_result    res [MAX_RES];

        w      = eff_width();
        h      = eff_height();
        r      = cur_row;
        c      = cur_col;
        n      = 0;
        stored = line_mem[c % MAX_W];
        mid    = stored[0];
        top    = stored[1];
        cur    = {pix, mid, top};
        w1     = win_cols[2:0];
        w2     = win_cols[5:3];

        // Pixel up and left of the current one; only interior pixels erode.
        if (r >= 1 && c >= 1) begin
            ero = (r >= 2 && c >= 2 && r - 1 <= h - 2 && c - 1 <= w - 2 &&
                   cur == 3'b111 && w1 == 3'b111 && w2 == 3'b111);
            res[n] = make_result(r - 1, c - 1, w1[1], ero);
            n++;
        end
        // Last column of the previous row is a border pixel.
        if (r >= 1 && c == w - 1) begin
            res[n] = make_result(r - 1, c, mid, 1'b0);
            n++;
        end
        // Every pixel of the last row is a border pixel.
        if (r == h - 1) begin
            res[n] = make_result(r, c, pix, 1'b0);
            n++;
        end
        for (int k = 0; k < n; k++) begin
            res[k].last = (k == n - 1);
            boundary_expect.push_back(res[k]);
        end

        line_mem[c % MAX_W] = {mid, pix};
        win_cols            = {w1, cur};
        if (c >= w - 1) begin
            cur_col = 0;
            cur_row = (r >= h - 1) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    // A write to a mapped register restarts the frame.
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_FRAME_WIDTH) begin
            reg_width = data[FW_W-1:0];
        end else if (idx == REG_FRAME_HEIGHT) begin
            reg_height = data[FH_W-1:0];
        end else begin
            return;
        end
        cur_row  = 0;
        cur_col  = 0;
        win_cols = '0;
    endtask

    // Pixel driver: one transaction per pending item, random gaps between.
    always @(negedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pix_taken) begin
            // Transaction still pending; keep the pixel steady.
        end else if (pix_gap > 0) begin
            pix_gap--;
            i_valid <= 1'b0;
        end else if (pix_pending.size() > 0) begin
            i_pixel <= pix_pending.pop_front();
            i_valid <= 1'b1;
            pix_issued++;
            draw_idle(pix_burst, pix_gap);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Result side: a random stall after every accepted result.
    always @(negedge i_clk) begin : ready_driver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (res_taken) begin
                draw_idle(res_burst, res_stall);
            end
            if (res_stall > 0) begin
                res_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks results, feeds the predictor and runs the watchdog.
    always @(posedge i_clk) begin : monitor
        t_result want;

        pix_taken = 1'b0;
        res_taken = 1'b0;
        cfg_taken = 1'b0;
        if (i_rst_n) begin
            // Results are checked before this edge's pixel is predicted.
            if (o_valid && i_ready) begin
                res_taken = 1'b1;
                res_checked++;
                if (boundary_expect.size() == 0) begin
                    report_error($sformatf("unexpected result at (%0d,%0d)",
                                           o_out_row, o_out_col));
                end else begin
                    want = boundary_expect.pop_front();
                    if (o_out_row !== want.row)
                        report_error($sformatf("row %0d, expected %0d",
                                               o_out_row, want.row));
                    if (o_out_col !== want.col)
                        report_error($sformatf("col %0d, expected %0d",
                                               o_out_col, want.col));
                    if (o_eroded !== want.eroded)
                        report_error($sformatf("eroded %b at (%0d,%0d), expected %b",
                                               o_eroded, want.row, want.col,
                                               want.eroded));
                    if (o_boundary !== want.boundary)
                        report_error($sformatf("boundary %b at (%0d,%0d), expected %b",
                                               o_boundary, want.row, want.col,
                                               want.boundary));
                    if (o_last_of_run !== want.last)
                        report_error($sformatf("last_of_run %b at (%0d,%0d), expected %b",
                                               o_last_of_run, want.row, want.col,
                                               want.last));
                end
            end
            if (i_valid && o_ready) begin
                pix_taken = 1'b1;
                pix_accepted++;
                predict_boundary(i_pixel);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_taken = 1'b1;
                cfg_writes++;
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (pix_taken || res_taken || cfg_taken) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= STALL_LIMIT) begin
                $display("No transaction for %0d cycles, %0d results outstanding.",
                         STALL_LIMIT, boundary_expect.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Register write; starts and ends on a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every pixel is in and every result is out, then settles.
    task automatic wait_idle;
        while (pix_pending.size() != 0 || pix_accepted != pix_issued ||
               boundary_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_pixels(input int count, input int density);
        for (int k = 0; k < count; k++) begin
            pix_pending.push_back($urandom_range(0, 99) < density);
        end
    endtask

    // Main sequence.
    initial begin : stimulus
        int w_data;
        int h_data;
        int w;
        int h;
        int count;
        int density;
        int rnd_pixels;

        rnd_pixels = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: a few pixels of row 0, which give no results.
        pix_pending.push_back(1'b1);
        pix_pending.push_back(1'b0);
        pix_pending.push_back(1'b1);
        pix_pending.push_back(1'b1);
        wait_idle();

        // 3x3 of ones: only the centre erodes. Writes to unmapped indexes
        // half-way through the frame must leave it running.
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        push_pixels(4, 100);
        wait_idle();
        write_reg(REG_UNMAPPED_LO, 13'h1FFF);
        write_reg(REG_UNMAPPED_HI, 0);
        push_pixels(5, 100);
        wait_idle();

        // Zero geometry is used as a single pixel.
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        pix_pending.push_back(1'b1);
        pix_pending.push_back(1'b0);
        wait_idle();

        // 2x2 frame: every pixel is on the border.
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 2);
        push_pixels(4, 100);
        wait_idle();

        // Width bits above the register are dropped, leaving a one-pixel row.
        write_reg(REG_FRAME_WIDTH, 13'h1800);
        write_reg(REG_FRAME_HEIGHT, 3);
        pix_pending.push_back(1'b1);
        pix_pending.push_back(1'b1);
        pix_pending.push_back(1'b0);
        wait_idle();
        directed_pix = pix_accepted;

        // Random geometries, mostly whole small frames of random density.
        while (rnd_pixels < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w_data = $urandom_range(0, (1 << CFG_DATA_W) - 1);
                1:       w_data = $urandom_range(1, 2);
                2:       w_data = MAX_W;
                default: w_data = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
                0:       h_data = $urandom_range(0, (1 << CFG_DATA_W) - 1);
                1:       h_data = $urandom_range(1, 2);
                2:       h_data = ($urandom_range(0, 1) != 0) ? MAX_H : 13'h1FFF;
                default: h_data = $urandom_range(3, 8);
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(REG_FRAME_WIDTH, w_data);
                1: write_reg(REG_FRAME_HEIGHT, h_data);
                2: begin
                    write_reg(REG_FRAME_HEIGHT, h_data);
                    write_reg(REG_FRAME_WIDTH, w_data);
                end
                3: begin
                    // No write: carry on with the frame in progress.
                end
                default: begin
                    write_reg(REG_FRAME_WIDTH, w_data);
                    write_reg(REG_FRAME_HEIGHT, h_data);
                end
            endcase
            w = eff_width();
            h = eff_height();
            case ($urandom_range(0, 3))
                0:       density = 50;
                1:       density = 90;
                2:       density = 100;
                default: density = 10;
            endcase
            if (w * h <= 120) begin
                count = $urandom_range(1, 3) * w * h;
                if ($urandom_range(0, 3) == 0) begin
                    count += $urandom_range(1, w);
                end
            end else begin
                count = $urandom_range(20, 60);
            end
            // Keep the random part of the run within its pixel budget.
            if (count > RANDOM_PIXELS - rnd_pixels) begin
                count = RANDOM_PIXELS - rnd_pixels;
            end
            push_pixels(count, density);
            rnd_pixels += count;
            wait_idle();
        end

        $display("Run covered %0d pixels (%0d directed) over %0d register writes;",
                 pix_accepted, directed_pix, cfg_writes);
        $display("%0d results checked, %0d mismatches.", res_checked, err_count);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
src/bbe_pkg.sv
src/bbe_ram.sv
src/bbe_core.sv
src/bbe_fifo.sv
src/binary_boundary_extract_3x3.sv
dv/tb.sv
